FILE: rtl/core/gsit_pkg.sv
// Shared constants, codes and types for the generational slot id table.
package gsit_pkg;

   localparam int SLOTS     = 1024;
   localparam int SLOT_W    = $clog2(SLOTS);
   localparam int HEAD_W    = SLOT_W + 1;
   localparam int GEN_SHIFT = 12;
   localparam int ID_W      = 31;
   localparam int RUN_W     = 32;
   localparam int CMD_W     = 2;
   localparam int STAT_W    = 2;

   localparam logic [CMD_W-1:0] CMD_ALLOC  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_LOOKUP = 2'd1;
   localparam logic [CMD_W-1:0] CMD_FREE   = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RUN    = 2'd3;

   localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_BAD  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_EXEC
   } state_type;

   typedef struct packed {
      logic clear_en;
      logic read_en;
      logic exec_en;
   } dp_ctl_type;

   typedef struct packed {
      logic clear_last;
   } dp_stat_type;

endpackage

FILE: rtl/core/gsit_ctrl.sv
// Controller state machine: clearing pass, request acceptance and result handoff.
module gsit_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output gsit_pkg::dp_ctl_type ctl,
   input  gsit_pkg::dp_stat_type stat
);
   import gsit_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      rsp_valid_ff;
   logic      rsp_valid_in;
   logic      out_free;

   assign out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR: begin
            if (stat.clear_last) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_CLEAR;
         end
      endcase
   end

   always_comb begin
      req_ready    = (state_ff == S_IDLE);
      ctl.clear_en = (state_ff == S_CLEAR);
      ctl.read_en  = (state_ff == S_IDLE) && req_valid;
      ctl.exec_en  = (state_ff == S_EXEC) && out_free;
      if (ctl.exec_en) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

FILE: rtl/core/gsit_dp.sv
// Datapath: slot memories, free-list head, current slot and result registers.
module gsit_dp (
   input  logic                          clock,
   input  logic                          reset,
   input  gsit_pkg::dp_ctl_type          ctl,
   output gsit_pkg::dp_stat_type         stat,
   input  logic [gsit_pkg::CMD_W-1:0]    req_cmd,
   input  logic [gsit_pkg::ID_W-1:0]     req_env_id,
   input  logic [gsit_pkg::ID_W-1:0]     req_owner_id,
   input  logic                          req_check_perm,
   input  logic [gsit_pkg::SLOT_W-1:0]   req_slot,
   output logic [gsit_pkg::STAT_W-1:0]   rsp_status,
   output logic [gsit_pkg::SLOT_W-1:0]   rsp_slot_out,
   output logic [gsit_pkg::ID_W-1:0]     rsp_id_out,
   output logic                          rsp_none_found,
   output logic [gsit_pkg::RUN_W-1:0]    rsp_run_count
);
   import gsit_pkg::*;

   localparam logic [ID_W:0] GEN_INC  = (ID_W + 1)'(1) << GEN_SHIFT;
   localparam logic [ID_W:0] GEN_MASK = ~((ID_W + 1)'(SLOTS - 1));

   // Entry word holds the busy flag above the id.
   logic [ID_W:0]   entry_mem [SLOTS];
   logic [HEAD_W-1:0] next_mem [SLOTS];
   logic [ID_W-1:0] parent_mem [SLOTS];
   logic [RUN_W-1:0] runs_mem [SLOTS];

   logic [ID_W:0]     entry_rd_ff;
   logic [HEAD_W-1:0] next_rd_ff;
   logic [ID_W-1:0]   parent_rd_ff;
   logic [RUN_W-1:0]  runs_rd_ff;

   logic [CMD_W-1:0]  cmd_ff;
   logic [ID_W-1:0]   env_id_ff;
   logic [ID_W-1:0]   owner_id_ff;
   logic              perm_ff;
   logic [SLOT_W-1:0] addr_ff;
   logic [SLOT_W-1:0] rd_addr;

   logic [HEAD_W-1:0] head_ff;
   logic [HEAD_W-1:0] head_in;
   logic [SLOT_W-1:0] cur_slot_ff;
   logic [SLOT_W-1:0] cur_slot_in;
   logic              cur_valid_ff;
   logic              cur_valid_in;
   logic [ID_W-1:0]   cur_id_ff;
   logic [ID_W-1:0]   cur_id_in;
   logic [SLOT_W-1:0] clear_idx_ff;

   logic              ent_we;
   logic [ID_W:0]     ent_wd;
   logic              nxt_we;
   logic              par_we;
   logic              run_we;
   logic [RUN_W-1:0]  run_wd;

   logic [STAT_W-1:0] status_in;
   logic [SLOT_W-1:0] slot_out_in;
   logic [ID_W-1:0]   id_out_in;
   logic              none_in;
   logic [RUN_W-1:0]  run_count_in;

   logic              old_busy;
   logic [ID_W-1:0]   old_id;
   logic [ID_W:0]     gen;
   logic [ID_W-1:0]   new_id;
   logic [RUN_W-1:0]  runs_inc;
   logic              is_cur;

   logic [STAT_W-1:0] rsp_status_ff;
   logic [SLOT_W-1:0] rsp_slot_out_ff;
   logic [ID_W-1:0]   rsp_id_out_ff;
   logic              rsp_none_found_ff;
   logic [RUN_W-1:0]  rsp_run_count_ff;

   assign stat.clear_last = (clear_idx_ff == SLOT_W'(SLOTS - 1));

   always_comb begin
      unique case (req_cmd)
         CMD_ALLOC:  rd_addr = head_ff[SLOT_W-1:0];
         CMD_LOOKUP: rd_addr = req_env_id[SLOT_W-1:0];
         CMD_FREE:   rd_addr = req_slot;
         CMD_RUN:    rd_addr = req_slot;
         default:    rd_addr = req_slot;
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.read_en) begin
         entry_rd_ff  <= entry_mem[rd_addr];
         next_rd_ff   <= next_mem[rd_addr];
         parent_rd_ff <= parent_mem[rd_addr];
         runs_rd_ff   <= runs_mem[rd_addr];
         cmd_ff       <= req_cmd;
         env_id_ff    <= req_env_id;
         owner_id_ff  <= req_owner_id;
         perm_ff      <= req_check_perm;
         addr_ff      <= rd_addr;
      end
   end

   assign old_busy = entry_rd_ff[ID_W];
   assign old_id   = entry_rd_ff[ID_W-1:0];
   assign runs_inc = runs_rd_ff + RUN_W'(1);
   assign is_cur   = cur_valid_ff && (cur_slot_ff == addr_ff);

   always_comb begin
      gen = ({1'b0, old_id} + GEN_INC) & GEN_MASK;
      if ((gen == '0) || gen[ID_W]) begin
         gen = GEN_INC;
      end
      new_id = gen[ID_W-1:0] | ID_W'(addr_ff);
   end

   always_comb begin
      status_in    = STAT_BAD;
      slot_out_in  = '0;
      id_out_in    = '0;
      none_in      = 1'b0;
      run_count_in = '0;
      ent_we       = 1'b0;
      ent_wd       = entry_rd_ff;
      nxt_we       = 1'b0;
      par_we       = 1'b0;
      run_we       = 1'b0;
      run_wd       = '0;
      head_in      = head_ff;
      cur_slot_in  = cur_slot_ff;
      cur_valid_in = cur_valid_ff;
      cur_id_in    = cur_id_ff;
      unique case (cmd_ff)
         CMD_ALLOC: begin
            if (head_ff[SLOT_W]) begin
               status_in = STAT_FULL;
            end else begin
               ent_we      = 1'b1;
               ent_wd      = {1'b1, new_id};
               par_we      = 1'b1;
               run_we      = 1'b1;
               run_wd      = '0;
               head_in     = next_rd_ff;
               status_in   = STAT_OK;
               slot_out_in = addr_ff;
               id_out_in   = new_id;
            end
         end
         CMD_LOOKUP: begin
            if (env_id_ff == '0) begin
               status_in = STAT_OK;
               if (cur_valid_ff) begin
                  slot_out_in = cur_slot_ff;
                  id_out_in   = cur_id_ff;
               end else begin
                  none_in = 1'b1;
               end
            end else if (old_busy && (old_id == env_id_ff) &&
                         (!perm_ff || is_cur ||
                          (cur_valid_ff && (parent_rd_ff == cur_id_ff)))) begin
               status_in   = STAT_OK;
               slot_out_in = addr_ff;
               id_out_in   = old_id;
            end
         end
         CMD_FREE: begin
            if (old_busy) begin
               ent_we      = 1'b1;
               ent_wd      = {1'b0, old_id};
               nxt_we      = 1'b1;
               head_in     = {1'b0, addr_ff};
               status_in   = STAT_OK;
               slot_out_in = addr_ff;
               id_out_in   = old_id;
               if (is_cur) begin
                  cur_valid_in = 1'b0;
               end
            end
         end
         CMD_RUN: begin
            if (old_busy) begin
               status_in   = STAT_OK;
               slot_out_in = addr_ff;
               id_out_in   = old_id;
               if (is_cur) begin
                  run_count_in = runs_rd_ff;
               end else begin
                  cur_slot_in  = addr_ff;
                  cur_valid_in = 1'b1;
                  cur_id_in    = old_id;
                  run_we       = 1'b1;
                  run_wd       = runs_inc;
                  run_count_in = runs_inc;
               end
            end
         end
         default: begin
            status_in = STAT_BAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (ctl.clear_en) begin
         entry_mem[clear_idx_ff] <= '0;
      end else if (ctl.exec_en && ent_we) begin
         entry_mem[addr_ff] <= ent_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.clear_en) begin
         next_mem[clear_idx_ff] <= HEAD_W'(clear_idx_ff) + HEAD_W'(1);
      end else if (ctl.exec_en && nxt_we) begin
         next_mem[addr_ff] <= head_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.exec_en && par_we) begin
         parent_mem[addr_ff] <= owner_id_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.exec_en && run_we) begin
         runs_mem[addr_ff] <= run_wd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff      <= '0;
         cur_slot_ff  <= '0;
         cur_valid_ff <= 1'b0;
         clear_idx_ff <= '0;
      end else begin
         if (ctl.clear_en) begin
            clear_idx_ff <= clear_idx_ff + SLOT_W'(1);
         end
         if (ctl.exec_en) begin
            head_ff      <= head_in;
            cur_slot_ff  <= cur_slot_in;
            cur_valid_ff <= cur_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.exec_en) begin
         cur_id_ff         <= cur_id_in;
         rsp_status_ff     <= status_in;
         rsp_slot_out_ff   <= slot_out_in;
         rsp_id_out_ff     <= id_out_in;
         rsp_none_found_ff <= none_in;
         rsp_run_count_ff  <= run_count_in;
      end
   end

   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_out   = rsp_slot_out_ff;
   assign rsp_id_out     = rsp_id_out_ff;
   assign rsp_none_found = rsp_none_found_ff;
   assign rsp_run_count  = rsp_run_count_ff;

endmodule

FILE: rtl/core/generational_slot_id_table.sv
// Top level of the generational slot id table.
//
// Requests arrive on the req_ channel: req_cmd selects alloc, lookup, free
// or run, and the other fields carry the id, owner id, permission flag and
// slot index. Each request transaction produces exactly one response
// transaction on the rsp_ channel with status, slot, id, none_found and the
// run count.
// At the accept edge a request reads all slot memories at one address; in the
// execute state the block then computes the result, writes the memories back
// and loads the response register. The next request is not accepted until the
// previous one leaves the execute state: each is one read-modify-write through
// the slot memories. After reset a clearing pass runs over the entry memory and
// the free-list links of all 1024 slots, with req_ready low.
// When the receiver stalls, one response waits in the output register while
// the next request is accepted and read; that request then holds until the
// output register is taken.
module generational_slot_id_table (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic [gsit_pkg::CMD_W-1:0]    req_cmd,
   input  logic [gsit_pkg::ID_W-1:0]     req_env_id,
   input  logic [gsit_pkg::ID_W-1:0]     req_owner_id,
   input  logic                          req_check_perm,
   input  logic [gsit_pkg::SLOT_W-1:0]   req_slot,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [gsit_pkg::STAT_W-1:0]   rsp_status,
   output logic [gsit_pkg::SLOT_W-1:0]   rsp_slot_out,
   output logic [gsit_pkg::ID_W-1:0]     rsp_id_out,
   output logic                          rsp_none_found,
   output logic [gsit_pkg::RUN_W-1:0]    rsp_run_count
);
   import gsit_pkg::*;

   dp_ctl_type  ctl;
   dp_stat_type stat;

   gsit_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .ctl       (ctl),
      .stat      (stat)
   );

   gsit_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .ctl            (ctl),
      .stat           (stat),
      .req_cmd        (req_cmd),
      .req_env_id     (req_env_id),
      .req_owner_id   (req_owner_id),
      .req_check_perm (req_check_perm),
      .req_slot       (req_slot),
      .rsp_status     (rsp_status),
      .rsp_slot_out   (rsp_slot_out),
      .rsp_id_out     (rsp_id_out),
      .rsp_none_found (rsp_none_found),
      .rsp_run_count  (rsp_run_count)
   );

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the generational slot id table.
`timescale 1ns / 1ps

module testbench;
   import gsit_pkg::*;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [ID_W-1:0]   env_id;
      logic [ID_W-1:0]   owner_id;
      logic              check_perm;
      logic [SLOT_W-1:0] slot;
   } command_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      logic [SLOT_W-1:0] slot_out;
      logic [ID_W-1:0]   id_out;
      logic              none_found;
      logic [RUN_W-1:0]  run_count;
   } answer_type;

   typedef enum logic [1:0] {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;
   typedef enum logic [1:0] {PICK_BUSY, PICK_CHILD, PICK_FREED} pick_type;

   localparam logic [ID_W+1:0] GEN_STEP = (ID_W + 2)'(1) << GEN_SHIFT;
   localparam logic [ID_W+1:0] LOW_MASK = (ID_W + 2)'(SLOTS - 1);
   localparam logic [ID_W+1:0] ID_MAX   = {2'b00, {ID_W{1'b1}}};
   localparam int unsigned PHASES       = 8;
   localparam int unsigned PHASE_ITEMS  = 20;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [CMD_W-1:0]    req_cmd = CMD_LOOKUP;
   logic [ID_W-1:0]     req_env_id = '0;
   logic [ID_W-1:0]     req_owner_id = '0;
   logic                req_check_perm = 1'b0;
   logic [SLOT_W-1:0]   req_slot = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [STAT_W-1:0]   rsp_status;
   logic [SLOT_W-1:0]   rsp_slot_out;
   logic [ID_W-1:0]     rsp_id_out;
   logic                rsp_none_found;
   logic [RUN_W-1:0]    rsp_run_count;

   command_type   commands_queued[$];
   answer_type    answers_due[$];
   answer_type    answer_seen;
   idle_mode_type idle_mode = IDLE_NONE;
   int unsigned   failures = 0;

   logic [ID_W-1:0]   slot_ident [SLOTS];
   logic              slot_live  [SLOTS];
   logic [ID_W-1:0]   slot_owner [SLOTS];
   logic [RUN_W-1:0]  slot_runs  [SLOTS];
   logic [HEAD_W-1:0] free_link  [SLOTS];
   logic [HEAD_W-1:0] free_top;
   logic [SLOT_W-1:0] active_slot;
   logic              active_valid;

   generational_slot_id_table dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_env_id     (req_env_id),
      .req_owner_id   (req_owner_id),
      .req_check_perm (req_check_perm),
      .req_slot       (req_slot),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_status     (rsp_status),
      .rsp_slot_out   (rsp_slot_out),
      .rsp_id_out     (rsp_id_out),
      .rsp_none_found (rsp_none_found),
      .rsp_run_count  (rsp_run_count)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   function automatic void reset_table();
      for (int i = 0; i < SLOTS; i++) begin
         slot_ident[i] = '0;
         slot_live[i]  = 1'b0;
         slot_owner[i] = '0;
         slot_runs[i]  = '0;
         free_link[i]  = HEAD_W'(i + 1);
      end
      free_top     = '0;
      active_slot  = '0;
      active_valid = 1'b0;
   endfunction

   function automatic logic [ID_W-1:0] fresh_id(logic [ID_W-1:0] old, logic [SLOT_W-1:0] idx);
      logic [ID_W+1:0] gen;
      gen = ({2'b00, old} + GEN_STEP) & ~LOW_MASK;
      if (gen == '0 || gen > ID_MAX) begin
         gen = GEN_STEP;
      end
      return gen[ID_W-1:0] | ID_W'(idx);
   endfunction

   // Applies one command to the table copy and returns the answer it must produce.
   function automatic answer_type apply_command(command_type c);
      answer_type        a;
      logic [SLOT_W-1:0] e;
      a = '0;
      a.status = STAT_BAD;
      unique case (c.cmd)
         CMD_ALLOC: begin
            if (free_top >= SLOTS) begin
               a.status = STAT_FULL;
            end else begin
               e = free_top[SLOT_W-1:0];
               slot_ident[e] = fresh_id(slot_ident[e], e);
               slot_owner[e] = c.owner_id;
               slot_live[e]  = 1'b1;
               slot_runs[e]  = '0;
               free_top      = free_link[e];
               a.status   = STAT_OK;
               a.slot_out = e;
               a.id_out   = slot_ident[e];
            end
         end
         CMD_LOOKUP: begin
            if (c.env_id == '0) begin
               a.status = STAT_OK;
               if (active_valid) begin
                  a.slot_out = active_slot;
                  a.id_out   = slot_ident[active_slot];
               end else begin
                  a.none_found = 1'b1;
               end
            end else begin
               e = c.env_id[SLOT_W-1:0];
               if (slot_live[e] && slot_ident[e] == c.env_id &&
                   (!c.check_perm || (active_valid && (e == active_slot ||
                    slot_owner[e] == slot_ident[active_slot])))) begin
                  a.status   = STAT_OK;
                  a.slot_out = e;
                  a.id_out   = slot_ident[e];
               end
            end
         end
         CMD_FREE: begin
            if (slot_live[c.slot]) begin
               slot_live[c.slot] = 1'b0;
               free_link[c.slot] = free_top;
               free_top = {1'b0, c.slot};
               if (active_valid && active_slot == c.slot) begin
                  active_valid = 1'b0;
               end
               a.status   = STAT_OK;
               a.slot_out = c.slot;
               a.id_out   = slot_ident[c.slot];
            end
         end
         default: begin
            if (slot_live[c.slot]) begin
               if (!active_valid || active_slot != c.slot) begin
                  active_slot  = c.slot;
                  active_valid = 1'b1;
                  slot_runs[c.slot] = slot_runs[c.slot] + RUN_W'(1);
               end
               a.status    = STAT_OK;
               a.slot_out  = c.slot;
               a.id_out    = slot_ident[c.slot];
               a.run_count = slot_runs[c.slot];
            end
         end
      endcase
      return a;
   endfunction

   function automatic void check_field(string name, logic [RUN_W-1:0] want,
                                       logic [RUN_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
         failures++;
      end
   endfunction

   function automatic bit pick_slot(pick_type kind, output logic [SLOT_W-1:0] s);
      logic [SLOT_W-1:0] k;
      bit                hit;
      k = SLOT_W'($urandom);
      s = k;
      for (int n = 0; n < SLOTS; n++) begin
         unique case (kind)
            PICK_BUSY:  hit = slot_live[k];
            PICK_CHILD: hit = slot_live[k] && active_valid &&
                              slot_owner[k] == slot_ident[active_slot];
            default:    hit = !slot_live[k] && slot_ident[k] != '0;
         endcase
         if (hit) begin
            s = k;
            return 1'b1;
         end
         k++;
      end
      return 1'b0;
   endfunction

   function automatic void queue_command(logic [CMD_W-1:0] cmd, logic [ID_W-1:0] env,
                                         logic [ID_W-1:0] parent, logic perm,
                                         logic [SLOT_W-1:0] s);
      commands_queued.push_back({cmd, env, parent, perm, s});
   endfunction

   // Builds one command of the given kind from the current table contents.
   task automatic queue_random(logic [CMD_W-1:0] cmd);
      command_type       c;
      logic [SLOT_W-1:0] s;
      int unsigned       roll;
      while (commands_queued.size() != 0) @(negedge clock);
      c.cmd        = cmd;
      c.env_id     = ID_W'($urandom);
      c.owner_id   = ID_W'($urandom);
      c.check_perm = 1'($urandom);
      c.slot       = SLOT_W'($urandom);
      roll = $urandom_range(99);
      unique case (cmd)
         CMD_ALLOC: begin
            if (roll < 40 && active_valid) begin
               c.owner_id = slot_ident[active_slot];
            end else if (roll < 70 && pick_slot(PICK_BUSY, s)) begin
               c.owner_id = slot_ident[s];
            end
         end
         CMD_LOOKUP: begin
            if (roll < 8) begin
               c.env_id = '0;
            end else if (roll < 30 && pick_slot(PICK_CHILD, s)) begin
               c.env_id     = slot_ident[s];
               c.check_perm = ($urandom_range(3) != 0);
            end else if (roll < 65 && pick_slot(PICK_BUSY, s)) begin
               c.env_id = slot_ident[s];
            end else if (roll < 75 && pick_slot(PICK_FREED, s)) begin
               c.env_id = slot_ident[s];
            end else if (roll < 85 && pick_slot(PICK_BUSY, s)) begin
               c.env_id = slot_ident[s] ^ (ID_W'(1) << $urandom_range(ID_W - 1));
            end
         end
         default: begin
            if (cmd == CMD_RUN && roll < 20 && active_valid) begin
               c.slot = active_slot;
            end else if (roll < 80 && pick_slot(PICK_BUSY, s)) begin
               c.slot = s;
            end
         end
      endcase
      commands_queued.push_back(c);
   endtask

   task automatic drain_all();
      while (commands_queued.size() != 0 || req_valid || answers_due.size() != 0) begin
         @(negedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         reset_table();
      end else begin
         if (req_valid && req_ready) begin
            answers_due.push_back(apply_command({req_cmd, req_env_id, req_owner_id,
                                                 req_check_perm, req_slot}));
         end
         if (!req_valid || req_ready) begin
            if (commands_queued.size() != 0 &&
                !((idle_mode == IDLE_SEND && $urandom_range(99) < 80) ||
                  (idle_mode == IDLE_BOTH && $urandom_range(99) < 22))) begin
               req_valid <= 1'b1;
               {req_cmd, req_env_id, req_owner_id, req_check_perm, req_slot}
                  <= commands_queued.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (answers_due.size() == 0) begin
               $error("Response transaction arrived with no answer due.");
               failures++;
            end else begin
               answer_seen = answers_due.pop_front();
               check_field("status", RUN_W'(answer_seen.status), RUN_W'(rsp_status));
               check_field("slot_out", RUN_W'(answer_seen.slot_out), RUN_W'(rsp_slot_out));
               check_field("id_out", RUN_W'(answer_seen.id_out), RUN_W'(rsp_id_out));
               check_field("none_found", RUN_W'(answer_seen.none_found),
                           RUN_W'(rsp_none_found));
               check_field("run_count", answer_seen.run_count, rsp_run_count);
            end
         end
         rsp_ready <= !((idle_mode == IDLE_RECV && $urandom_range(99) < 80) ||
                        (idle_mode == IDLE_BOTH && $urandom_range(99) < 22));
      end
   end

   initial begin
      int unsigned roll;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      queue_command(CMD_LOOKUP, 31'd0, 31'd0, 1'b0, 10'd0);
      queue_command(CMD_LOOKUP, 31'd4096, 31'd0, 1'b0, 10'd0);
      queue_command(CMD_FREE, 31'd0, 31'd0, 1'b0, 10'd5);
      queue_command(CMD_RUN, 31'd0, 31'd0, 1'b0, 10'd1023);
      queue_command(CMD_ALLOC, 31'd0, 31'd0, 1'b0, 10'd0);
      queue_command(CMD_ALLOC, 31'd0, 31'd4096, 1'b0, 10'd0);
      queue_command(CMD_LOOKUP, 31'd4097, 31'd0, 1'b1, 10'd0);
      queue_command(CMD_RUN, 31'd0, 31'd0, 1'b0, 10'd0);
      queue_command(CMD_RUN, 31'd0, 31'd0, 1'b0, 10'd0);
      queue_command(CMD_LOOKUP, 31'd0, 31'd0, 1'b1, 10'd0);
      queue_command(CMD_LOOKUP, 31'd4097, 31'd0, 1'b1, 10'd0);
      queue_command(CMD_LOOKUP, 31'd4096, 31'd0, 1'b1, 10'd0);
      queue_command(CMD_ALLOC, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 1'b1, 10'd1023);
      queue_command(CMD_LOOKUP, 31'd4098, 31'd0, 1'b1, 10'd0);
      queue_command(CMD_LOOKUP, 31'd4098, 31'd0, 1'b0, 10'd0);
      queue_command(CMD_LOOKUP, 31'd8193, 31'd0, 1'b0, 10'd0);
      queue_command(CMD_RUN, 31'd0, 31'd0, 1'b0, 10'd2);
      queue_command(CMD_FREE, 31'd0, 31'd0, 1'b0, 10'd2);
      queue_command(CMD_LOOKUP, 31'd0, 31'd0, 1'b0, 10'd0);
      queue_command(CMD_ALLOC, 31'd0, 31'd4097, 1'b0, 10'd0);
      queue_command(CMD_LOOKUP, 31'd4098, 31'd0, 1'b0, 10'd0);
      queue_command(CMD_FREE, 31'd0, 31'd0, 1'b0, 10'd1023);
      queue_command(CMD_LOOKUP, 31'h7FFF_FFFF, 31'd0, 1'b1, 10'd0);
      queue_command(CMD_RUN, 31'd0, 31'd0, 1'b0, 10'd1);
      drain_all();

      // Fill the table until the free list runs dry, then hit it a few more times.
      while (free_top < SLOTS) begin
         queue_random(CMD_ALLOC);
      end
      repeat (3) queue_random(CMD_ALLOC);
      drain_all();

      for (int unsigned phase = 0; phase < PHASES; phase++) begin
         idle_mode = idle_mode_type'(phase % 4);
         for (int unsigned n = 0; n < PHASE_ITEMS; n++) begin
            roll = $urandom_range(99);
            if (phase % 2 == 1) begin
               if (roll < 10)      queue_random(CMD_ALLOC);
               else if (roll < 50) queue_random(CMD_LOOKUP);
               else if (roll < 85) queue_random(CMD_FREE);
               else                queue_random(CMD_RUN);
            end else begin
               if (roll < 25)      queue_random(CMD_ALLOC);
               else if (roll < 65) queue_random(CMD_LOOKUP);
               else if (roll < 80) queue_random(CMD_FREE);
               else                queue_random(CMD_RUN);
            end
         end
         drain_all();
      end

      repeat (10) @(negedge clock);
      if (failures == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
